>>> rtl/core/sprite_frame_sequencer_assert.svh
// Assertion macros shared by the sprite frame sequencer RTL.
`ifndef SPRITE_FRAME_SEQUENCER_ASSERT_SVH
`define SPRITE_FRAME_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SFS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sprite_frame_sequencer: assertion failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sprite_frame_sequencer: assertion failed");

`endif

>>> rtl/core/sfs_pkg.sv
// Types and constants for the sprite frame sequencer.
`default_nettype none

package sfs_pkg;

    localparam int FRAME_W    = 9;
    localparam int OUT_FRAME_W = 8;
    localparam int PERIOD_W   = 40;
    localparam int SCALE_W    = 16;
    localparam int DELTA_W    = 16;
    localparam int PROD_W     = DELTA_W + SCALE_W;
    localparam int ACC_W      = 48;
    localparam int SLOTS      = 4;
    localparam int SLOT_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 40;

    // Upper limit on the frame count that the sequencer honors.
    localparam logic [FRAME_W-1:0] MAX_FRAMES = 9'd256;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FRAME_COUNT    = 3'd0,
        CFG_FRAME_PERIOD   = 3'd1,
        CFG_PLAY_SCALE     = 3'd2,
        CFG_LOOP_ENABLE    = 3'd3,
        CFG_REVERSE_ENABLE = 3'd4,
        CFG_NOTIFY_FRAMES  = 3'd5,
        CFG_NOTIFY_ENABLE  = 3'd6
    } t_cfg_idx;

    typedef enum logic {
        ACT_TICK    = 1'b0,
        ACT_RESTART = 1'b1
    } t_action;

endpackage

`default_nettype wire

>>> rtl/core/sprite_frame_sequencer.sv
// Sprite animation frame sequencer: time accumulator, frame stepping and notify slots.
// A request passes through the input register, the product register and the
// result register.
// Throughput: one request per cycle while the result side is not stalled; the accumulator and frame update in one pass.
// A stalled result register does not block requests while earlier stages hold bubbles.
// Reset (synchronous, active low) clears the pipeline, the state and loads register defaults.
`default_nettype none
`include "sprite_frame_sequencer_assert.svh"

module sprite_frame_sequencer (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [sfs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [sfs_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_action,
    input  wire logic [sfs_pkg::DELTA_W-1:0]     i_delta_time,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [sfs_pkg::OUT_FRAME_W-1:0]      o_frame,
    output logic                                 o_animation_end,
    output logic [sfs_pkg::SLOTS-1:0]            o_notify_fired
);
    import sfs_pkg::*;

    // Configuration registers.
    logic [FRAME_W-1:0]      r_frame_count;
    logic [PERIOD_W-1:0]     r_frame_period;
    logic [SCALE_W-1:0]      r_play_scale;
    logic                    r_loop_enable;
    logic                    r_reverse_enable;
    logic [SLOTS*SLOT_W-1:0] r_notify_frames;
    logic [SLOTS-1:0]        r_notify_enable;

    // Pipeline registers.
    logic                    r_i_vld;
    logic                    r_i_action;
    logic [DELTA_W-1:0]      r_i_delta;
    logic                    r_p_vld;
    logic                    r_p_action;
    logic [PROD_W-1:0]       r_p_prod;
    logic                    r_o_vld;
    logic [OUT_FRAME_W-1:0]  r_o_frame;
    logic                    r_o_end;
    logic [SLOTS-1:0]        r_o_fired;

    // Sequencer state.
    logic [ACC_W-1:0]        r_acc;
    logic [FRAME_W-1:0]      r_cur_frame;
    logic [SLOTS-1:0]        r_notify_called;

    logic                    out_adv;
    logic                    p_rdy;
    logic                    i_rdy;
    logic                    in_take;
    logic                    p_load;
    logic                    out_load;

    logic [FRAME_W-1:0]      count;
    logic [ACC_W:0]          sum;
    logic [ACC_W-1:0]        sat;
    logic [ACC_W:0]          diff;
    logic                    stepped;
    logic                    ended_c;
    logic                    match_valid;
    logic [FRAME_W-1:0]      match_frame;
    logic [SLOTS-1:0]        fired_c;
    logic [ACC_W-1:0]        n_acc;
    logic [FRAME_W-1:0]      n_cur_frame;
    logic [SLOTS-1:0]        n_notify_called;

    logic                    restart_load;
    logic                    keep_load;

    // Each stage moves when the stage after it is empty or moving.
    assign out_adv    = !r_o_vld || !i_out_stall;
    assign p_rdy      = !r_p_vld || out_adv;
    assign i_rdy      = !r_i_vld || p_rdy;
    assign o_in_stall = !i_rdy;
    assign in_take    = i_in_valid && i_rdy;
    assign p_load     = r_i_vld && p_rdy;
    assign out_load   = r_p_vld && out_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count    <= 9'd1;
            r_frame_period   <= 40'd256;
            r_play_scale     <= 16'd256;
            r_loop_enable    <= 1'b1;
            r_reverse_enable <= 1'b0;
            r_notify_frames  <= '0;
            r_notify_enable  <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_FRAME_COUNT:    r_frame_count    <= i_cfg_wr_data[FRAME_W-1:0];
                CFG_FRAME_PERIOD:   r_frame_period   <= i_cfg_wr_data[PERIOD_W-1:0];
                CFG_PLAY_SCALE:     r_play_scale     <= i_cfg_wr_data[SCALE_W-1:0];
                CFG_LOOP_ENABLE:    r_loop_enable    <= i_cfg_wr_data[0];
                CFG_REVERSE_ENABLE: r_reverse_enable <= i_cfg_wr_data[0];
                CFG_NOTIFY_FRAMES:  r_notify_frames  <= i_cfg_wr_data[SLOTS*SLOT_W-1:0];
                CFG_NOTIFY_ENABLE:  r_notify_enable  <= i_cfg_wr_data[SLOTS-1:0];
                default: ;
            endcase
        end
    end

    // Frame count as used: zero counts as one, large values clamp.
    always_comb begin
        if (r_frame_count == '0) begin
            count = 9'd1;
        end else if (r_frame_count > MAX_FRAMES) begin
            count = MAX_FRAMES;
        end else begin
            count = r_frame_count;
        end
    end

    always_comb begin
        sum     = {1'b0, r_acc} + {{(ACC_W + 1 - PROD_W){1'b0}}, r_p_prod};
        sat     = sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
        diff    = {1'b0, sat} - {{(ACC_W + 1 - PERIOD_W){1'b0}}, r_frame_period};
        stepped = !diff[ACC_W];
        n_acc   = stepped ? diff[ACC_W-1:0] : sat;

        ended_c     = 1'b0;
        match_valid = 1'b1;
        n_cur_frame = r_cur_frame;
        if (stepped) begin
            if (r_reverse_enable) begin
                if (r_cur_frame == '0) begin
                    ended_c     = 1'b1;
                    match_valid = 1'b0;
                end else begin
                    n_cur_frame = r_cur_frame - 9'd1;
                end
            end else begin
                n_cur_frame = r_cur_frame + 9'd1;
                ended_c     = (n_cur_frame >= count);
            end
        end
        match_frame = n_cur_frame;

        // The check sees the overrun frame before it is reloaded.
        for (int k = 0; k < SLOTS; k++) begin
            fired_c[k] = match_valid && r_notify_enable[k] && !r_notify_called[k] &&
                ({1'b0, r_notify_frames[k*SLOT_W +: SLOT_W]} == match_frame);
        end
        n_notify_called = r_notify_called | fired_c;

        if (ended_c) begin
            if (r_loop_enable) begin
                n_cur_frame = r_reverse_enable ? (count - 9'd1) : '0;
            end else begin
                n_cur_frame = r_reverse_enable ? '0 : (count - 9'd1);
            end
            n_notify_called = '0;
        end

        if (t_action'(r_p_action) == ACT_RESTART) begin
            n_acc           = '0;
            n_cur_frame     = '0;
            n_notify_called = '0;
            ended_c         = 1'b0;
            fired_c         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_vld         <= 1'b0;
            r_p_vld         <= 1'b0;
            r_o_vld         <= 1'b0;
            r_acc           <= '0;
            r_cur_frame     <= '0;
            r_notify_called <= '0;
        end else begin
            if (i_rdy) begin
                r_i_vld <= i_in_valid;
            end
            if (p_rdy) begin
                r_p_vld <= r_i_vld;
            end
            if (out_adv) begin
                r_o_vld <= r_p_vld;
            end
            if (out_load) begin
                r_acc           <= n_acc;
                r_cur_frame     <= n_cur_frame;
                r_notify_called <= n_notify_called;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_i_action <= i_action;
            r_i_delta  <= i_delta_time;
        end
        if (p_load) begin
            r_p_action <= r_i_action;
            r_p_prod   <= r_i_delta * r_play_scale;
        end
        if (out_load) begin
            r_o_frame <= n_cur_frame[OUT_FRAME_W-1:0];
            r_o_end   <= ended_c;
            r_o_fired <= fired_c;
        end
    end

    assign o_out_valid     = r_o_vld;
    assign o_frame         = r_o_frame;
    assign o_animation_end = r_o_end;
    assign o_notify_fired  = r_o_fired;

    assign restart_load = out_load && (t_action'(r_p_action) == ACT_RESTART);
    assign keep_load    = out_load && !ended_c;

    `SFS_ASSERT_NEXT(a_restart_clears, i_clk, i_rst_n, restart_load, {r_o_frame, r_o_end, r_o_fired} == '0)
    `SFS_ASSERT_NEXT(a_end_rearms, i_clk, i_rst_n, out_load && ended_c, r_notify_called == '0)
    `SFS_ASSERT_NEXT(a_fired_recorded, i_clk, i_rst_n, keep_load, (r_o_fired & ~r_notify_called) == '0)

endmodule

`default_nettype wire

>>> tb/sfs_frame_checker.sv
// Checker for the sprite frame sequencer: predicts each step result and compares it.
module sfs_frame_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [sfs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sfs_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_action,
    input  logic [sfs_pkg::DELTA_W-1:0]     i_delta_time,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [sfs_pkg::OUT_FRAME_W-1:0] i_frame,
    input  logic                            i_animation_end,
    input  logic [sfs_pkg::SLOTS-1:0]       i_notify_fired,
    output int                              o_fail_count,
    output int                              o_pending
);
    import sfs_pkg::*;

    typedef struct packed {
        logic [OUT_FRAME_W-1:0] frame;
        logic                   ended;
        logic [SLOTS-1:0]       fired;
    } t_frame_step;

    // Register shadow.
    logic [FRAME_W-1:0]       seq_frame_count;
    logic [PERIOD_W-1:0]      seq_frame_period;
    logic [SCALE_W-1:0]       seq_play_scale;
    logic                     seq_loop;
    logic                     seq_reverse;
    logic [SLOTS*SLOT_W-1:0]  seq_notify_frames;
    logic [SLOTS-1:0]         seq_notify_enable;

    // Sequencer state.
    logic [ACC_W-1:0]         elapsed_acc;
    logic [FRAME_W-1:0]       frame_pos;
    logic [SLOTS-1:0]         slots_done;

    t_frame_step expected_steps[$];
    int          fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic report_mismatch(input string msg);
        fail_total++;
        $display("[%0t] sfs_frame_checker: %s", $time, msg);
    endtask

    task automatic advance_animation(input logic act, input logic [DELTA_W-1:0] dt,
                                     output t_frame_step res);
        logic [ACC_W:0]     sum;
        logic [FRAME_W-1:0] limit;
        logic [FRAME_W-1:0] hit_frame;
        logic               hit_ok;
        logic               ended;
        logic [SLOTS-1:0]   fired;
        res = '0;
        if (act == ACT_RESTART) begin
            frame_pos = '0;
            elapsed_acc = '0;
            slots_done = '0;
            return;
        end
        if (seq_frame_count == 0)
            limit = 9'd1;
        else if (seq_frame_count > MAX_FRAMES)
            limit = MAX_FRAMES;
        else
            limit = seq_frame_count;

        sum = {1'b0, elapsed_acc} + dt * seq_play_scale;
        elapsed_acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];

        hit_frame = frame_pos;
        hit_ok = 1'b1;
        ended = 1'b0;
        if (elapsed_acc >= seq_frame_period) begin
            elapsed_acc = elapsed_acc - seq_frame_period;
            if (seq_reverse) begin
                // Stepping below frame zero is an end that no slot can match.
                if (frame_pos == 0) begin
                    ended = 1'b1;
                    hit_ok = 1'b0;
                end else begin
                    frame_pos = frame_pos - 1'b1;
                    hit_frame = frame_pos;
                end
            end else begin
                frame_pos = frame_pos + 1'b1;
                hit_frame = frame_pos;
                ended = (frame_pos >= limit);
            end
        end

        fired = '0;
        if (hit_ok) begin
            for (int k = 0; k < SLOTS; k++) begin
                if (seq_notify_enable[k] && !slots_done[k] &&
                    {1'b0, seq_notify_frames[k*SLOT_W +: SLOT_W]} == hit_frame) begin
                    slots_done[k] = 1'b1;
                    fired[k] = 1'b1;
                end
            end
        end

        if (ended) begin
            if (seq_loop)
                frame_pos = seq_reverse ? limit - 1'b1 : '0;
            else
                frame_pos = seq_reverse ? '0 : limit - 1'b1;
            slots_done = '0;
        end

        res.frame = frame_pos[OUT_FRAME_W-1:0];
        res.ended = ended;
        res.fired = fired;
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_step want;
        if (!i_rst_n) begin
            seq_frame_count = 9'd1;
            seq_frame_period = 40'd256;
            seq_play_scale = 16'd256;
            seq_loop = 1'b1;
            seq_reverse = 1'b0;
            seq_notify_frames = '0;
            seq_notify_enable = '0;
            elapsed_acc = '0;
            frame_pos = '0;
            slots_done = '0;
            expected_steps.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_steps.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: frame %0d end %0b notify %b",
                                              i_frame, i_animation_end, i_notify_fired));
                end else begin
                    want = expected_steps.pop_front();
                    if (i_frame !== want.frame)
                        report_mismatch($sformatf("frame %0d, expected %0d", i_frame, want.frame));
                    if (i_animation_end !== want.ended)
                        report_mismatch($sformatf("animation_end %0b, expected %0b",
                                                  i_animation_end, want.ended));
                    if (i_notify_fired !== want.fired)
                        report_mismatch($sformatf("notify_fired %b, expected %b",
                                                  i_notify_fired, want.fired));
                end
            end
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_FRAME_COUNT:    seq_frame_count = i_cfg_wr_data[FRAME_W-1:0];
                    CFG_FRAME_PERIOD:   seq_frame_period = i_cfg_wr_data[PERIOD_W-1:0];
                    CFG_PLAY_SCALE:     seq_play_scale = i_cfg_wr_data[SCALE_W-1:0];
                    CFG_LOOP_ENABLE:    seq_loop = i_cfg_wr_data[0];
                    CFG_REVERSE_ENABLE: seq_reverse = i_cfg_wr_data[0];
                    CFG_NOTIFY_FRAMES:  seq_notify_frames = i_cfg_wr_data[SLOTS*SLOT_W-1:0];
                    CFG_NOTIFY_ENABLE:  seq_notify_enable = i_cfg_wr_data[SLOTS-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                advance_animation(i_action, i_delta_time, want);
                expected_steps.push_back(want);
            end
        end
        o_pending <= expected_steps.size();
    end

endmodule

>>> tb/tb.sv
// Testbench top for the sprite frame sequencer: stimulus, idling and the verdict.
module tb;
    import sfs_pkg::*;

    localparam int PIPE_DEPTH     = 3;
    localparam int RUN_LIMIT      = 12_000_000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_REQUESTS = 150;
    // Full-scale ticks with a zero period, each one a frame step.
    localparam int BIG_TICKS      = 40;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_wr_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic                   i_action;
    logic [DELTA_W-1:0]     i_delta_time;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [OUT_FRAME_W-1:0] o_frame;
    logic                   o_animation_end;
    logic [SLOTS-1:0]       o_notify_fired;

    int fail_count;
    int pending_count;
    bit idling;
    int stall_left;

    sprite_frame_sequencer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_delta_time    (i_delta_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_frame         (o_frame),
        .o_animation_end (o_animation_end),
        .o_notify_fired  (o_notify_fired)
    );

    sfs_frame_checker frame_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_delta_time    (i_delta_time),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_frame         (o_frame),
        .i_animation_end (o_animation_end),
        .i_notify_fired  (o_notify_fired),
        .o_fail_count    (fail_count),
        .o_pending       (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("** sprite_frame_sequencer: FAILED **");
        $finish;
    end

    // Result side: random stall bursts while idling is on.
    initial begin
        i_out_stall = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if (!i_out_stall && idling && $urandom_range(0, 5) == 0) begin
                i_out_stall = 1'b1;
                stall_left = $urandom_range(0, 13);
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // All driving tasks start and end just after a falling edge.
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wr_en = 1'b1;
        i_cfg_addr = idx;
        i_cfg_wr_data = val;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (pending_count != 0)
            @(negedge i_clk);
        repeat (PIPE_DEPTH + 2) @(negedge i_clk);
    endtask

    task automatic load_sequence(input logic [FRAME_W-1:0] cnt, input logic [PERIOD_W-1:0] per,
                                 input logic [SCALE_W-1:0] scl, input logic lp, input logic rv,
                                 input logic [31:0] nf, input logic [SLOTS-1:0] ne);
        wait_idle();
        write_reg(CFG_FRAME_COUNT, cnt);
        write_reg(CFG_FRAME_PERIOD, per);
        write_reg(CFG_PLAY_SCALE, scl);
        write_reg(CFG_LOOP_ENABLE, lp);
        write_reg(CFG_REVERSE_ENABLE, rv);
        write_reg(CFG_NOTIFY_FRAMES, nf);
        write_reg(CFG_NOTIFY_ENABLE, ne);
    endtask

    // Valid stays high on return; the caller either presents the next request
    // in the same step or drops valid.
    task automatic send_req(input t_action act, input logic [DELTA_W-1:0] dt);
        if (idling && $urandom_range(0, 4) == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_action = act;
        i_delta_time = dt;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic tick(input logic [DELTA_W-1:0] dt);
        send_req(ACT_TICK, dt);
    endtask

    task automatic run_phase(input bit with_idle);
        logic [FRAME_W-1:0]  cnt;
        logic [PERIOD_W-1:0] per;
        logic [SCALE_W-1:0]  scl;
        logic [DELTA_W-1:0]  dt;
        logic [31:0]         nf;
        logic [63:0]         wide;
        t_action             act;
        case ($urandom_range(0, 7))
            0: cnt = 9'd0;
            1: cnt = 9'd1;
            2: cnt = 9'd256;
            3: cnt = 9'($urandom_range(257, 511));
            4: cnt = 9'($urandom_range(1, 256));
            default: cnt = 9'($urandom_range(2, 12));
        endcase
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: per = '0;
            1: per = '1;
            2: per = wide[PERIOD_W-1:0];
            3: per = 40'd1;
            default: per = 40'($urandom_range(1, 4096));
        endcase
        case ($urandom_range(0, 5))
            0: scl = '0;
            1: scl = '1;
            2: scl = 16'($urandom);
            default: scl = 16'($urandom_range(1, 512));
        endcase
        for (int k = 0; k < SLOTS; k++)
            nf[k*SLOT_W +: SLOT_W] = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                 : 8'($urandom_range(0, 12));
        load_sequence(cnt, per, scl, 1'($urandom), 1'($urandom), nf, SLOTS'($urandom));
        idling = with_idle;
        repeat (PHASE_REQUESTS) begin
            act = ($urandom_range(0, 19) == 0) ? ACT_RESTART : ACT_TICK;
            dt = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
            send_req(act, dt);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_addr = CFG_FRAME_COUNT;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_action = ACT_TICK;
        i_delta_time = '0;
        idling = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Defaults after reset: one frame, so every step is an end.
        idling = 1'b1;
        tick(16'd0);
        tick(16'd1);
        send_req(ACT_RESTART, 16'hFFFF);
        tick(16'hFFFF);

        // Clamped forward run; the last slot sits on the overrun frame.
        load_sequence(9'd4, 40'd1000, 16'hFFFF, 1'b0, 1'b0, 32'h0402_0100, 4'hF);
        tick(16'd0);
        tick(16'd1);
        tick(16'hFFFF);
        tick(16'd0);
        tick(16'd0);
        tick(16'd0);
        send_req(ACT_RESTART, 16'd0);
        tick(16'd0);

        // Zero frame count, zero period and zero scale, looping in reverse.
        load_sequence(9'd0, 40'd0, 16'd0, 1'b1, 1'b1, 32'hFFFF_FFFF, 4'h5);
        tick(16'h8000);
        tick(16'd0);

        // Frame count above the maximum; the reverse wrap lands on frame 255.
        load_sequence(9'h1FF, 40'd1, 16'd1, 1'b1, 1'b1, 32'hFF80_01FF, 4'hF);
        tick(16'd1);
        tick(16'd0);
        tick(16'd1);

        // Shrink the frame count below the current frame.
        load_sequence(9'd8, 40'd256, 16'd256, 1'b1, 1'b0, 32'd0, 4'h0);
        send_req(ACT_RESTART, 16'd0);
        repeat (5) tick(16'd1);
        wait_idle();
        write_reg(CFG_FRAME_COUNT, 9'd2);
        tick(16'd1);

        // Full-scale ticks build up the accumulator; then the longest period stays above it, so no frame step follows.
        load_sequence(9'd256, 40'd0, 16'hFFFF, 1'b1, 1'b0, 32'd0, 4'h0);
        idling = 1'b0;
        repeat (BIG_TICKS) tick(16'hFFFF);
        load_sequence(9'd256, '1, 16'd0, 1'b0, 1'b1, $urandom, 4'hF);
        repeat (20) tick(16'($urandom));

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_phase((p < RANDOM_PHASES - 1) && (p % 3 != 2));

        wait_idle();
        if (fail_count == 0)
            $display("** sprite_frame_sequencer: PASSED **");
        else
            $display("** sprite_frame_sequencer: FAILED **");
        $finish;
    end

endmodule
